[rtl/decimal_text_to_fixed_point_top_assert.svh]
// Assertion macros used by the checker file of the text-to-fixed-point block.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_ASSERT_SVH

// Outside reset, cond in one cycle implies res in the next cycle.
`define DTFP_ASSERT_NEXT(lbl, cond, res) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error("next-cycle rule violated");

// Outside reset, cond in one cycle implies sig unchanged in the next cycle.
`define DTFP_ASSERT_STABLE(lbl, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("stalled word changed");

// A cycle in reset implies res in the next cycle.
`define DTFP_ASSERT_AFTER_RESET(lbl, res) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (res)) \
    else $error("state after reset is wrong");

`endif

[rtl/dtfp_pkg.sv]
// Package with shared types, widths and the power-of-ten table.
package dtfp_pkg;

  // Default parameter values.
  localparam int DefFracBits     = 16;
  localparam int DefIntBits      = 16;
  localparam int DefMaxFracDigit = 9;

  // Fixed widths of the datapath.
  localparam int AccW   = 48;   // digit accumulator
  localparam int CntW   = 4;    // fraction digit count
  localparam int DivW   = 40;   // 10^12 fits in 40 bits
  localparam int QuoW   = 33;   // kept quotient bits, larger values flag overflow
  localparam int MagW   = QuoW + 1;
  localparam int ValueW = 32;
  localparam int QDepth = 2;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  // One parsed string handed from the parser to the finisher.
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [CntW-1:0] frac_cnt;
    logic            negative;
    logic            clipped;
  } dtfp_entry_t;

  // Powers of ten for the fraction digit counts in use.
  function automatic logic [DivW-1:0] pow10(input logic [CntW-1:0] n);
    logic [DivW-1:0] p;
    case (n)
      4'd0:    p = 40'd1;
      4'd1:    p = 40'd10;
      4'd2:    p = 40'd100;
      4'd3:    p = 40'd1000;
      4'd4:    p = 40'd10000;
      4'd5:    p = 40'd100000;
      4'd6:    p = 40'd1000000;
      4'd7:    p = 40'd10000000;
      4'd8:    p = 40'd100000000;
      4'd9:    p = 40'd1000000000;
      4'd10:   p = 40'd10000000000;
      4'd11:   p = 40'd100000000000;
      4'd12:   p = 40'd1000000000000;
      default: p = 40'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/dtfp_front.sv]
// Character parser: takes one byte per accepted cycle and builds the digit accumulator.
module dtfp_front #(
  parameter int MAX_FRAC_DIGITS = dtfp_pkg::DefMaxFracDigit
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_marker,
  output logic                 push,
  output dtfp_pkg::dtfp_entry_t push_data
);
  import dtfp_pkg::*;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [CntW-1:0] FracLimit = CntW'(MAX_FRAC_DIGITS);

  typedef enum logic [3:0] {
    PH_SKIP = 4'b0001,
    PH_INT  = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [AccW-1:0]   acc_r, acc_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              clip_r, clip_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [AccW+4:0]   mac;
  logic              mac_ovf;
  logic [AccW-1:0]   dig_acc;

  // Accumulator times ten plus the new digit, saturating at all ones.
  assign is_digit = in_text_byte inside {[ChZero:ChNine]};
  assign digit    = 4'(in_text_byte - ChZero);
  assign mac      = {2'b00, acc_r, 3'b000} + {4'b0000, acc_r, 1'b0} + {{(AccW+1){1'b0}}, digit};
  assign mac_ovf  = |mac[AccW+4:AccW];
  assign dig_acc  = mac_ovf ? AccMax : mac[AccW-1:0];

  // Next parser state.
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    clip_nxt  = clip_r;
    if (in_accept) begin
      if (in_end_marker) begin
        phase_nxt = PH_SKIP;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        clip_nxt  = 1'b0;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (in_text_byte == ChSpace) begin
              phase_nxt = PH_SKIP;
            end else if (in_text_byte == ChMinus) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_INT;
            end else if (in_text_byte == ChPlus) begin
              phase_nxt = PH_INT;
            end else if (is_digit) begin
              acc_nxt   = dig_acc;
              clip_nxt  = clip_r | mac_ovf;
              phase_nxt = PH_INT;
            end else if (in_text_byte == ChPoint) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_INT: begin
            if (is_digit) begin
              acc_nxt  = dig_acc;
              clip_nxt = clip_r | mac_ovf;
            end else if (in_text_byte == ChPoint) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              // Digits past the limit are dropped.
              if (cnt_r < FracLimit) begin
                acc_nxt  = dig_acc;
                clip_nxt = clip_r | mac_ovf;
                cnt_nxt  = cnt_r + 1'b1;
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      cnt_r   <= '0;
      clip_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      clip_r  <= clip_nxt;
    end
  end

  // The end marker hands the finished string to the queue.
  assign push               = in_accept & in_end_marker;
  assign push_data.acc      = acc_r;
  assign push_data.frac_cnt = cnt_r;
  assign push_data.negative = neg_r;
  assign push_data.clipped  = clip_r;

endmodule

[rtl/dtfp_queue.sv]
// Two-entry queue of parsed strings between the parser and the finisher.
module dtfp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dtfp_pkg::dtfp_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output dtfp_pkg::dtfp_entry_t pop_data,
  output logic                  empty
);
  import dtfp_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int FillW = $clog2(QDepth + 1);

  dtfp_entry_t       slot_r [QDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FillW-1:0]  fill_r, fill_nxt;

  assign full     = (fill_r == FillW'(QDepth));
  assign empty    = (fill_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/dtfp_back.sv]
// Finisher: bit-serial division by the power of ten, rounding, sign and saturation.
module dtfp_back #(
  parameter int FRAC_BITS = dtfp_pkg::DefFracBits,
  parameter int INT_BITS  = dtfp_pkg::DefIntBits
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  dtfp_pkg::dtfp_entry_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_value,
  output logic                  out_saturated
);
  import dtfp_pkg::*;

  localparam int Steps  = AccW + FRAC_BITS;
  localparam int StepW  = $clog2(Steps + 1);
  localparam int TotalW = (INT_BITS + FRAC_BITS > ValueW) ? ValueW : INT_BITS + FRAC_BITS;
  localparam logic [MagW-1:0] HalfRange = MagW'(1) << (TotalW - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AccW-1:0]   dvd_r, dvd_nxt;
  logic [DivW-1:0]   div_r, div_nxt;
  logic [DivW-1:0]   rem_r, rem_nxt;
  logic [QuoW-1:0]   quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic              neg_r, neg_nxt;
  logic              clip_r, clip_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              ov_r, ov_nxt;
  logic [ValueW-1:0] val_r, val_nxt;
  logic              sat_r, sat_nxt;

  logic [DivW:0]     rem_sh;
  logic              take;
  logic              round_up;
  logic [MagW-1:0]   mag;
  logic [MagW-1:0]   mag_lim;
  logic              sat_res;
  logic              out_free;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem_r, dvd_r[AccW-1]};
  assign take     = (rem_sh >= {1'b0, div_r});
  assign round_up = ({rem_r, 1'b0} >= {1'b0, div_r});
  assign mag      = {1'b0, quo_r} + {{(MagW-1){1'b0}}, round_up};
  assign out_free = !ov_r || out_ready;

  // Clamp the rounded magnitude to the signed range.
  always_comb begin
    mag_lim = mag;
    sat_res = 1'b0;
    if (neg_r) begin
      if (ovf_r || mag > HalfRange) begin
        mag_lim = HalfRange;
        sat_res = 1'b1;
      end
    end else begin
      if (ovf_r || mag > HalfRange - 1'b1) begin
        mag_lim = HalfRange - 1'b1;
        sat_res = 1'b1;
      end
    end
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    clip_nxt  = clip_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r;
    val_nxt   = val_r;
    sat_nxt   = sat_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          dvd_nxt   = q_data.acc;
          div_nxt   = pow10(q_data.frac_cnt);
          rem_nxt   = '0;
          quo_nxt   = '0;
          ovf_nxt   = 1'b0;
          neg_nxt   = q_data.negative;
          clip_nxt  = q_data.clipped;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = take ? DivW'(rem_sh - {1'b0, div_r}) : rem_sh[DivW-1:0];
        quo_nxt  = {quo_r[QuoW-2:0], take};
        ovf_nxt  = ovf_r | quo_r[QuoW-1];
        dvd_nxt  = {dvd_r[AccW-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(Steps - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          val_nxt   = neg_r ? ValueW'(-mag_lim) : ValueW'(mag_lim);
          sat_nxt   = clip_r | sat_res;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    clip_r <= clip_nxt;
    val_r  <= val_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_valid     = ov_r;
  assign out_value     = val_r;
  assign out_saturated = sat_r;

endmodule

[rtl/decimal_text_to_fixed_point_top.sv]
// Top level of the decimal text to fixed point converter.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+------------------------------
//   input   | in_valid, in_ready, in_text_byte,       | one character, or the end
//           | in_end_marker                           | marker closing the string
//   output  | out_valid, out_ready, out_value,        | parsed value, signed fixed
//           | out_saturated                           | point, and saturation flag
//
// The parser takes one character per cycle while the string queue has room.
// The finisher loads each string, runs the restoring divider at one quotient bit
// per cycle, then rounds, signs and saturates the result.
// The two-entry queue holds finished strings while the divider is busy.
// Reset clears the parser, queue pointers, sequencer and output valid.
// in_ready drops only while the queue is full.
module decimal_text_to_fixed_point_top #(
  parameter int FRAC_BITS       = dtfp_pkg::DefFracBits,
  parameter int INT_BITS        = dtfp_pkg::DefIntBits,
  parameter int MAX_FRAC_DIGITS = dtfp_pkg::DefMaxFracDigit
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_marker,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_saturated
);
  import dtfp_pkg::*;

  logic        in_accept;
  logic        push;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  dtfp_entry_t push_data;
  dtfp_entry_t pop_data;

  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  dtfp_front #(
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_text_byte (in_text_byte),
    .in_end_marker(in_end_marker),
    .push         (push),
    .push_data    (push_data)
  );

  dtfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  dtfp_back #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_saturated(out_saturated)
  );

endmodule

[rtl/dtfp_checker.sv]
// Port-level checker for the converter and its bind to the top level.
`include "decimal_text_to_fixed_point_top_assert.svh"

module dtfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_saturated
);

  // A result that is not taken stays offered with the same word.
  `DTFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `DTFP_ASSERT_STABLE(a_out_stable, out_valid && !out_ready, {out_value, out_saturated})

  // Reset leaves no result pending and the input side open.
  `DTFP_ASSERT_AFTER_RESET(a_reset_no_result, !out_valid)
  `DTFP_ASSERT_AFTER_RESET(a_reset_ready, in_ready)

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .out_saturated(out_saturated)
);

[sim/decimal_text_to_fixed_point_top_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the converter's fixed-point words and compares them with its output.
module decimal_text_to_fixed_point_top_checker #(
  parameter int FRAC_BITS       = dtfp_pkg::DefFracBits,
  parameter int INT_BITS        = dtfp_pkg::DefIntBits,
  parameter int MAX_FRAC_DIGITS = dtfp_pkg::DefMaxFracDigit
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_end_marker,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_value,
  input  logic               out_saturated,
  output int                 fail_count,
  output int                 pending_count
);

  // Character codes the scanner reacts to.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // The magnitude stops growing once it reaches this bound during scaling.
  localparam logic [63:0] MagClamp = 64'h100_0000_0000;
  localparam int unsigned FracLimit = (MAX_FRAC_DIGITS > 12) ? 12 : MAX_FRAC_DIGITS;

  typedef enum logic [3:0] {
    SCAN_SKIP = 4'b0001,
    SCAN_INT  = 4'b0010,
    SCAN_FRAC = 4'b0100,
    SCAN_DONE = 4'b1000
  } scan_phase_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
  } fixed_word_t;

  scan_phase_t             scan_phase;
  logic                    is_negative;
  logic [dtfp_pkg::AccW-1:0] digit_acc;
  int unsigned             frac_digits;
  logic                    acc_clipped;
  fixed_word_t             expected_words[$];

  // Start a new string.
  function automatic void clear_scan();
    scan_phase  = SCAN_SKIP;
    is_negative = 1'b0;
    digit_acc   = '0;
    frac_digits = 0;
    acc_clipped = 1'b0;
  endfunction

  // Append one decimal digit, pinning the accumulator at its maximum on overflow.
  function automatic void push_digit(input logic [7:0] ch);
    logic [63:0] wide;
    logic [7:0]  digit;
    digit = ch - ChZero;
    wide  = {16'd0, digit_acc} * 64'd10 + {56'd0, digit};
    if (digit_acc > dtfp_pkg::AccMax / 10 || wide > {16'd0, dtfp_pkg::AccMax}) begin
      digit_acc   = dtfp_pkg::AccMax;
      acc_clipped = 1'b1;
    end else begin
      digit_acc = wide[dtfp_pkg::AccW-1:0];
    end
  endfunction

  // Advance the scanner by one character word.
  function automatic void scan_char(input logic [7:0] ch);
    logic is_digit;
    is_digit = (ch >= ChZero) && (ch <= ChNine);
    case (scan_phase)
      SCAN_SKIP: begin
        if (ch == ChSpace) begin
          scan_phase = SCAN_SKIP;
        end else if (ch == ChMinus) begin
          is_negative = 1'b1;
          scan_phase  = SCAN_INT;
        end else if (ch == ChPlus) begin
          scan_phase = SCAN_INT;
        end else if (is_digit) begin
          push_digit(ch);
          scan_phase = SCAN_INT;
        end else if (ch == ChPoint) begin
          scan_phase = SCAN_FRAC;
        end else begin
          scan_phase = SCAN_DONE;
        end
      end
      SCAN_INT: begin
        if (is_digit) begin
          push_digit(ch);
        end else if (ch == ChPoint) begin
          scan_phase = SCAN_FRAC;
        end else begin
          scan_phase = SCAN_DONE;
        end
      end
      SCAN_FRAC: begin
        if (is_digit) begin
          // Digits past the limit are dropped without leaving the fraction.
          if (frac_digits < FracLimit) begin
            push_digit(ch);
            frac_digits++;
          end
        end else begin
          scan_phase = SCAN_DONE;
        end
      end
      default: scan_phase = SCAN_DONE;
    endcase
  endfunction

  // Scale the accumulated digits to fixed point, round and saturate.
  function automatic fixed_word_t fixed_value_of();
    fixed_word_t w;
    int unsigned used;
    int unsigned width;
    logic [63:0] divisor;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] half_range;
    logic [63:0] neg_mag;
    logic        qbit;
    used    = (frac_digits > FracLimit) ? FracLimit : frac_digits;
    divisor = 64'd1;
    for (int i = 0; i < used; i++) begin
      divisor = divisor * 64'd10;
    end
    mag   = {16'd0, digit_acc} / divisor;
    rem   = {16'd0, digit_acc} % divisor;
    width = (INT_BITS + FRAC_BITS > 32) ? 32 :
            ((INT_BITS + FRAC_BITS < 1) ? 1 : INT_BITS + FRAC_BITS);
    half_range  = 64'd1 << (width - 1);
    w.saturated = acc_clipped;

    // One quotient bit per fraction bit, as a long division.
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem  = rem << 1;
      qbit = (rem >= divisor);
      if (qbit) begin
        rem = rem - divisor;
      end
      if (mag >= MagClamp) begin
        mag = MagClamp;
      end else begin
        mag = (mag << 1) | {63'd0, qbit};
      end
    end
    // Round to nearest, ties away from zero.
    if (rem * 2 >= divisor) begin
      mag = mag + 64'd1;
    end

    if (is_negative) begin
      if (mag > half_range) begin
        mag         = half_range;
        w.saturated = 1'b1;
      end
      neg_mag = 64'd0 - mag;
      w.value = neg_mag[31:0];
    end else begin
      if (mag > half_range - 64'd1) begin
        mag         = half_range - 64'd1;
        w.saturated = 1'b1;
      end
      w.value = mag[31:0];
    end
    return w;
  endfunction

  // Watch both channels at every edge; results are checked before new words are scanned.
  always @(posedge clk) begin : watch
    int          bad;
    fixed_word_t want;
    if (!rst_n) begin
      clear_scan();
      expected_words.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      bad = 0;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: value %0d saturated %0b",
                 out_value, out_saturated);
          bad++;
        end else begin
          want = expected_words.pop_front();
          if (out_value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_value);
            bad++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, out_saturated);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_end_marker) begin
          expected_words.push_back(fixed_value_of());
          clear_scan();
        end else begin
          scan_char(in_text_byte);
        end
      end
      fail_count    <= fail_count + bad;
      pending_count <= expected_words.size();
    end
  end

endmodule

[sim/decimal_text_to_fixed_point_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top: drives character words into the converter and reports the verdict.
module decimal_text_to_fixed_point_top_tb;

  localparam string DigitChars = "0123456789";

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_text_byte;
  logic               in_end_marker;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic               out_saturated;

  int fail_count;
  int pending_count;
  int tx_idle_pct;
  int rx_idle_pct = 0;
  int words_sent;
  int strings_sent;

  logic [7:0] text_buf[$];

  decimal_text_to_fixed_point_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_end_marker (in_end_marker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

  decimal_text_to_fixed_point_top_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_text_byte  (in_text_byte),
    .in_end_marker (in_end_marker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_saturated (out_saturated),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random according to the current profile.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("decimal_text_to_fixed_point_top_tb: done, errors");
    $finish;
  end

  // Offer one word and hold it until accepted; valid stays high between back-to-back words.
  task automatic send_word(input logic [7:0] ch, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= ch;
    in_end_marker <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_buf.push_back(s[i]);
    end
  endtask

  task automatic put_digits(input int n);
    repeat (n) text_buf.push_back(DigitChars[$urandom_range(0, 9)]);
  endtask

  task automatic put_sign();
    case ($urandom_range(0, 2))
      1: put_text("-");
      2: put_text("+");
      default: ;
    endcase
  endtask

  // Send the buffered characters, then the end marker with a random byte beside it.
  task automatic send_string();
    foreach (text_buf[i]) send_word(text_buf[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
    text_buf.delete();
    strings_sent++;
  endtask

  // Mostly well-formed numbers with random content, plus overflow, long fractions and noise.
  task automatic compose_random_string();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      repeat ($urandom_range(0, 2)) put_text(" ");
      put_sign();
      put_digits($urandom_range(0, 5));
      if ($urandom_range(0, 3) != 0) begin
        put_text(".");
        put_digits($urandom_range(0, 10));
      end
      if ($urandom_range(0, 3) == 0) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
        put_digits($urandom_range(0, 2));
      end
    end else if (kind < 70) begin
      // Enough integer digits to overflow the accumulator at times.
      put_sign();
      put_digits($urandom_range(13, 17));
      if ($urandom_range(0, 1) == 1) begin
        put_text(".");
        put_digits($urandom_range(0, 3));
      end
    end else if (kind < 80) begin
      // Fractions just below, at and beyond the digit limit.
      put_sign();
      put_digits($urandom_range(0, 2));
      put_text(".");
      put_digits($urandom_range(8, 12));
    end else if (kind < 90) begin
      // Around the edge of the representable range.
      put_sign();
      put_text("3276");
      put_digits(1);
      put_text(".");
      put_digits($urandom_range(0, 6));
    end else begin
      repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int tx_pct, input int rx_pct, input int word_goal);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (words_sent < word_goal) begin
      compose_random_string();
      send_string();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_text_byte  = '0;
    in_end_marker = 1'b0;
    tx_idle_pct   = 0;
    words_sent    = 0;
    strings_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: empty, negative zero, junk first with extreme bytes,
    // a space with a plus sign and a point, and saturation in both directions.
    send_string();
    put_text("-0");
    send_string();
    text_buf.push_back(8'hFF);
    put_text("7");
    send_string();
    text_buf.push_back(8'h00);
    send_string();
    put_text(" +1.5");
    send_string();
    put_text("-40000");
    send_string();
    put_text("99999");
    send_string();

    // Random strings under three idle profiles.
    run_random(31, 84, 580);
    run_random(84, 31, 1130);
    run_random(0, 0, 1650);
    in_valid <= 1'b0;

    // Drain all outstanding results, then allow one more finisher pass.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d words in %0d strings: directed edge cases, then random numbers,",
             words_sent, strings_sent);
    $display("accumulator overflows, long fractions and noise under three idle profiles.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("decimal_text_to_fixed_point_top_tb: done, clean");
    end else begin
      $display("decimal_text_to_fixed_point_top_tb: done, errors");
    end
    $finish;
  end

endmodule
